### hw/rtl/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB package
// Shared widths, constants, types and the hue ramp function of the converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

    localparam int HUE_W       = 9;
    localparam int PCT_W       = 7;
    localparam int CH_W        = 8;
    localparam int LVL_W       = 14;
    localparam int K_W         = 6;
    localparam int N_W         = 20;
    localparam int X_W         = 24;
    localparam int Y_W         = 18;
    localparam int QE_W        = 9;
    localparam int P_W         = 33;
    localparam int LANES       = 3;
    localparam int BACK_STAGES = 4;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    localparam logic [HUE_W-1:0] HUE_FULL  = HUE_W'(360);
    localparam logic [HUE_W-1:0] HUE_THIRD = HUE_W'(120);
    localparam logic [HUE_W-1:0] HUE_TWO3  = HUE_W'(240);
    localparam logic [HUE_W-1:0] HUE_RISE  = HUE_W'(60);
    localparam logic [HUE_W-1:0] HUE_HOLD  = HUE_W'(180);

    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_HALF = PCT_W'(50);

    localparam logic [LVL_W-1:0] LVL_ONE   = LVL_W'(10000);
    localparam logic [K_W-1:0]   K_MAX     = K_W'(60);
    localparam logic [N_W-1:0]   LO_SCALE  = N_W'(60);
    localparam logic [X_W-1:0]   N_SCALE   = X_W'(17);
    localparam logic [X_W-1:0]   ROUND_ADD = X_W'(20000);
    localparam int               PRE_SHIFT = 6;
    localparam logic [P_W-1:0]   RECIP     = P_W'(26843);
    localparam int               RECIP_SH  = 24;
    localparam logic [Y_W+1:0]   DIV_C     = (Y_W+2)'(625);
    localparam logic [QE_W:0]    CH_MAX    = (QE_W+1)'(255);

    typedef struct packed {
        logic [LVL_W-1:0]            lo;
        logic [LVL_W-1:0]            diff;
        logic [LANES-1:0][K_W-1:0]   k;
    } hsl_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hsl_fifo_stat_t;

    function automatic logic [K_W-1:0] hsl_ramp(input logic [HUE_W-1:0] t);
        logic [HUE_W-1:0] fall;
        begin
            fall = HUE_TWO3 - t;
            priority if (t < HUE_RISE)
                hsl_ramp = t[K_W-1:0];
            else if (t < HUE_HOLD)
                hsl_ramp = K_MAX;
            else if (t < HUE_TWO3)
                hsl_ramp = fall[K_W-1:0];
            else
                hsl_ramp = '0;
        end
    endfunction

endpackage

### hw/rtl/hsl_front.sv
// ----------------------------------------------------------------------------
// HSL front end
// Registers an accepted pixel, forms the two levels and the hue ramp positions.
// ----------------------------------------------------------------------------
module hsl_front
    import hsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [HUE_W-1:0]      hue,
    input  logic [PCT_W-1:0]      saturation,
    input  logic [PCT_W-1:0]      lightness,
    input  hsl_fifo_stat_t        fifo_stat,
    output logic                  push,
    output hsl_item_t             item
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [HUE_W-1:0]     h_reg;
    logic [PCT_W-1:0]     s_reg;
    logic [PCT_W-1:0]     l_reg;
    logic                 accept;

    logic [14:0]          prod_sl;
    logic [14:0]          hi_a;
    logic [14:0]          hi_b;
    logic [14:0]          hi_raw;
    logic [LVL_W-1:0]     hi;
    logic [15:0]          lo_full;
    logic [LVL_W-1:0]     lo;
    logic [HUE_W-1:0]     t_red;
    logic [HUE_W-1:0]     t_blue;

    assign push     = valid_reg && !fifo_stat.full;
    assign in_ready = !valid_reg || !fifo_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_reg <= (hue >= HUE_FULL) ? hue - HUE_FULL : hue;
            s_reg <= (saturation > PCT_FULL) ? PCT_FULL : saturation;
            l_reg <= (lightness > PCT_FULL) ? PCT_FULL : lightness;
        end
    end

    always_comb
    begin
        prod_sl = 15'(s_reg) * 15'(l_reg);
        hi_a    = 15'(l_reg) * (15'd100 + 15'(s_reg));
        hi_b    = 15'(l_reg) * 15'd100 + 15'(s_reg) * 15'd100 - prod_sl;
        hi_raw  = (l_reg < PCT_HALF) ? hi_a : hi_b;
        hi      = (hi_raw > 15'(LVL_ONE)) ? LVL_ONE : hi_raw[LVL_W-1:0];
        lo_full = 16'(l_reg) * 16'd200 - 16'(hi);
        lo      = lo_full[LVL_W-1:0];

        t_red  = (h_reg < HUE_TWO3)  ? h_reg + HUE_THIRD : h_reg - HUE_TWO3;
        t_blue = (h_reg < HUE_THIRD) ? h_reg + HUE_TWO3  : h_reg - HUE_THIRD;

        item.lo              = lo;
        item.diff            = hi - lo;
        item.k[LANE_RED]     = hsl_ramp(t_red);
        item.k[LANE_GREEN]   = hsl_ramp(h_reg);
        item.k[LANE_BLUE]    = hsl_ramp(t_blue);
    end

endmodule

### hw/rtl/hsl_fifo.sv
// ----------------------------------------------------------------------------
// HSL item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module hsl_fifo
    import hsl_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hsl_item_t       wr_data,
    input  logic            pop,
    output hsl_item_t       rd_data,
    output hsl_fifo_stat_t  stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hsl_item_t          mem [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW-1:0]      rd_ptr_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

### hw/rtl/hsl_back.sv
// ----------------------------------------------------------------------------
// HSL back end
// Four-stage pipeline that interpolates each channel and rounds it to 8 bits.
// ----------------------------------------------------------------------------
module hsl_back
    import hsl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hsl_fifo_stat_t        fifo_stat,
    input  hsl_item_t             item,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CH_W-1:0]       red,
    output logic [CH_W-1:0]       green,
    output logic [CH_W-1:0]       blue
);

    logic [BACK_STAGES-1:0]  valid_reg;
    logic [BACK_STAGES-1:0]  valid_next;
    logic                    adv;

    logic [N_W-1:0]   n_reg   [LANES];
    logic [N_W-1:0]   n_next  [LANES];
    logic [Y_W-1:0]   y_reg   [LANES];
    logic [Y_W-1:0]   y_next  [LANES];
    logic [Y_W-1:0]   y3_reg  [LANES];
    logic [QE_W-1:0]  qe_reg  [LANES];
    logic [QE_W-1:0]  qe_next [LANES];
    logic [CH_W-1:0]  ch_reg  [LANES];
    logic [CH_W-1:0]  ch_next [LANES];

    logic [X_W-1:0]   x_w     [LANES];
    logic [P_W-1:0]   p_w     [LANES];
    logic [Y_W+1:0]   base_w  [LANES];
    logic [QE_W:0]    q_w     [LANES];

    assign adv       = !valid_reg[BACK_STAGES-1] || out_ready;
    assign pop       = adv && !fifo_stat.empty;
    assign out_valid = valid_reg[BACK_STAGES-1];
    assign red       = ch_reg[LANE_RED];
    assign green     = ch_reg[LANE_GREEN];
    assign blue      = ch_reg[LANE_BLUE];

    always_comb
    begin
        valid_next = {valid_reg[BACK_STAGES-2:0], !fifo_stat.empty};
        for (int i = 0; i < LANES; i++)
        begin
            n_next[i]  = N_W'(item.lo) * LO_SCALE + N_W'(item.diff) * N_W'(item.k[i]);
            x_w[i]     = X_W'(n_reg[i]) * N_SCALE + ROUND_ADD;
            y_next[i]  = x_w[i][X_W-1:PRE_SHIFT];
            p_w[i]     = P_W'(y_reg[i]) * RECIP;
            qe_next[i] = p_w[i][RECIP_SH +: QE_W];
            base_w[i]  = (Y_W+2)'(qe_reg[i]) * DIV_C;
            if ((Y_W+2)'(y3_reg[i]) >= base_w[i] + DIV_C)
                q_w[i] = (QE_W+1)'(qe_reg[i]) + 1'b1;
            else
                q_w[i] = (QE_W+1)'(qe_reg[i]);
            ch_next[i] = (q_w[i] > CH_MAX) ? CH_MAX[CH_W-1:0] : q_w[i][CH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                n_reg[i]  <= n_next[i];
                y_reg[i]  <= y_next[i];
                y3_reg[i] <= y_reg[i];
                qe_reg[i] <= qe_next[i];
                ch_reg[i] <= ch_next[i];
            end
        end
    end

endmodule

### hw/rtl/hsl_to_rgb.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Converts one pixel from hue, saturation and lightness to 8-bit RGB.
//
//   Channel   Direction  Bits  Contents (lowest bit up)
//   s_axis    in         24    hue[8:0], saturation[15:9], lightness[22:16]
//   m_axis    out        24    red[7:0], green[15:8], blue[23:16]
//
// While m_axis_tready stays high, one pixel is accepted and one result leaves
// in every cycle. A pixel passes the front register, the queue write and the
// four back-end stages, of which the slowest holds one 18x15 multiplication.
// Reset clears the valid bits and the queue pointers; no clearing pass.
// A stall at the output freezes the back end, the queue takes FIFO_DEPTH
// pixels, the front register one more, and then s_axis_tready falls.
// ----------------------------------------------------------------------------
module hsl_to_rgb
    import hsl_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // hue, saturation, lightness, zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata    // red, green, blue
);

    hsl_fifo_stat_t   fifo_stat;
    hsl_item_t        wr_item;
    hsl_item_t        rd_item;
    logic             push;
    logic             pop;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    hsl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .hue        (s_axis_tdata[8:0]),
        .saturation (s_axis_tdata[15:9]),
        .lightness  (s_axis_tdata[22:16]),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .item       (wr_item)
    );

    hsl_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_item),
        .pop     (pop),
        .rd_data (rd_item),
        .stat    (fifo_stat)
    );

    hsl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .item      (rd_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_axis_tdata = {blue, green, red};

endmodule

### hw/rtl/hsl_chk.sv
// ----------------------------------------------------------------------------
// HSL to RGB checker
// Port-level assertions on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hsl_chk
    import hsl_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [23:0]  m_axis_tdata
);

    localparam int CAP = 1 + FIFO_DEPTH + BACK_STAGES;
    localparam int FW  = $clog2(CAP + 2);

    logic [FW-1:0]  inflight_reg;
    logic [FW-1:0]  inflight_next;
    logic           in_xfer;
    logic           out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
            inflight_next = inflight_reg + 1'b1;
        else if (out_xfer && !in_xfer)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result transfer changed.");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> inflight_reg != '0)
        else $error("Result transfer without a pixel in flight.");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == FW'(CAP) |-> !s_axis_tready)
        else $error("Pixel accepted beyond the converter's capacity.");

    a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> !m_axis_tvalid)
        else $error("Result offered with no pixel in flight.");

endmodule

bind hsl_to_rgb hsl_chk #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_hsl_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Sends pixels through the stream input and checks every output transfer
// against a predictor computed in exact integer arithmetic. A table of
// directed pixels comes first: extremes, sector edges, hue wrap and
// clamped fields. About 750 random pixels follow in three phases with
// different idle rates on each side.
// ----------------------------------------------------------------------------
module testbench;
    import hsl_pkg::*;

    localparam int DEG_RISE   = 60;
    localparam int DEG_HOLD   = 180;
    localparam int DEG_FALL   = 240;
    localparam int DEG_TURN   = 360;
    localparam int DEG_THIRD  = 120;
    localparam int PCT_TOP    = 100;
    localparam int PCT_MID    = 50;
    localparam int LEVEL_TOP  = 10000;
    localparam int RAMP_SPAN  = 60;
    localparam longint DENOM  = 600000;
    localparam int CH_TOP     = 255;
    localparam int PHASE_ITEMS = 250;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
        logic             known;
        rgb_t             want;
    } pixel_row_t;

    localparam rgb_t BLACK = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
    localparam rgb_t WHITE = '{blue: 8'd255, green: 8'd255, red: 8'd255};
    localparam rgb_t GREY  = '{blue: 8'd128, green: 8'd128, red: 8'd128};
    localparam rgb_t RED   = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
    localparam rgb_t GREEN = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
    localparam rgb_t BLUE  = '{blue: 8'd255, green: 8'd0,   red: 8'd0};

    localparam int DIRECTED_ROWS = 23;
    localparam pixel_row_t PIXEL_TABLE [DIRECTED_ROWS] = '{
        '{hue: 9'd0,   sat: 7'd0,   light: 7'd0,   known: 1'b1, want: BLACK},
        '{hue: 9'd0,   sat: 7'd0,   light: 7'd100, known: 1'b1, want: WHITE},
        '{hue: 9'd0,   sat: 7'd0,   light: 7'd50,  known: 1'b1, want: GREY},
        '{hue: 9'd0,   sat: 7'd100, light: 7'd50,  known: 1'b1, want: RED},
        '{hue: 9'd120, sat: 7'd100, light: 7'd50,  known: 1'b1, want: GREEN},
        '{hue: 9'd240, sat: 7'd100, light: 7'd50,  known: 1'b1, want: BLUE},
        '{hue: 9'd360, sat: 7'd100, light: 7'd50,  known: 1'b1, want: RED},
        '{hue: 9'd511, sat: 7'd127, light: 7'd127, known: 1'b1, want: WHITE},
        '{hue: 9'd0,   sat: 7'd127, light: 7'd0,   known: 1'b1, want: BLACK},
        '{hue: 9'd0,   sat: 7'd127, light: 7'd50,  known: 1'b1, want: RED},
        '{hue: 9'd60,  sat: 7'd100, light: 7'd50,  known: 1'b0, want: BLACK},
        '{hue: 9'd59,  sat: 7'd100, light: 7'd50,  known: 1'b0, want: BLACK},
        '{hue: 9'd179, sat: 7'd80,  light: 7'd30,  known: 1'b0, want: BLACK},
        '{hue: 9'd180, sat: 7'd80,  light: 7'd30,  known: 1'b0, want: BLACK},
        '{hue: 9'd239, sat: 7'd60,  light: 7'd70,  known: 1'b0, want: BLACK},
        '{hue: 9'd300, sat: 7'd100, light: 7'd50,  known: 1'b0, want: BLACK},
        '{hue: 9'd359, sat: 7'd100, light: 7'd50,  known: 1'b0, want: BLACK},
        '{hue: 9'd30,  sat: 7'd50,  light: 7'd49,  known: 1'b0, want: BLACK},
        '{hue: 9'd30,  sat: 7'd50,  light: 7'd50,  known: 1'b0, want: BLACK},
        '{hue: 9'd200, sat: 7'd37,  light: 7'd127, known: 1'b0, want: BLACK},
        '{hue: 9'd400, sat: 7'd90,  light: 7'd20,  known: 1'b0, want: BLACK},
        '{hue: 9'd90,  sat: 7'd1,   light: 7'd99,  known: 1'b0, want: BLACK},
        '{hue: 9'd210, sat: 7'd99,  light: 7'd1,   known: 1'b0, want: BLACK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    rgb_t        pending_rgb [$];
    int unsigned src_idle_pct = 18;
    int unsigned sink_idle_pct = 47;
    int unsigned mismatch_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned pixels_checked = 0;
    int unsigned clamped_sent = 0;

    hsl_to_rgb dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CH_W-1:0] profile_channel(input longint lo, input longint hi,
                                                        input int unsigned pos);
        longint ramp;
        longint num;
        begin
            if (pos < DEG_RISE)
                ramp = pos;
            else if (pos < DEG_HOLD)
                ramp = RAMP_SPAN;
            else if (pos < DEG_FALL)
                ramp = DEG_FALL - pos;
            else
                ramp = 0;
            num = RAMP_SPAN * lo + (hi - lo) * ramp;
            num = (2 * CH_TOP * num + DENOM) / (2 * DENOM);
            if (num > CH_TOP)
                num = CH_TOP;
            profile_channel = num[CH_W-1:0];
        end
    endfunction

    function automatic rgb_t hsl_convert(input logic [HUE_W-1:0] hue,
                                         input logic [PCT_W-1:0] sat,
                                         input logic [PCT_W-1:0] light);
        int unsigned h;
        longint s;
        longint l;
        longint hi;
        longint lo;
        rgb_t pix;
        begin
            h = hue % DEG_TURN;
            s = (sat > PCT_TOP) ? PCT_TOP : sat;
            l = (light > PCT_TOP) ? PCT_TOP : light;
            if (l < PCT_MID)
                hi = l * (PCT_TOP + s);
            else
                hi = PCT_TOP * l + PCT_TOP * s - s * l;
            if (hi > LEVEL_TOP)
                hi = LEVEL_TOP;
            lo = 2 * PCT_TOP * l - hi;
            pix.red   = profile_channel(lo, hi, (h + DEG_THIRD) % DEG_TURN);
            pix.green = profile_channel(lo, hi, h);
            pix.blue  = profile_channel(lo, hi, (h + 2 * DEG_THIRD) % DEG_TURN);
            hsl_convert = pix;
        end
    endfunction

    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [PCT_W-1:0] sat,
                              input logic [PCT_W-1:0] light, input rgb_t want);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= 24'($urandom);
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {1'b0, light, sat, hue};
            do
                @(posedge clk);
            while (!s_axis_tready);
            pending_rgb.push_back(want);
            pixels_sent++;
            if (sat > PCT_TOP || light > PCT_TOP || hue >= DEG_TURN)
                clamped_sent++;
        end
    endtask

    task automatic run_random_phase(input int unsigned src_pct, input int unsigned sink_pct);
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] light;
        begin
            src_idle_pct  = src_pct;
            sink_idle_pct = sink_pct;
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(7) == 0)
                begin
                    hue   = HUE_W'($urandom_range(511));
                    sat   = PCT_W'($urandom_range(127));
                    light = PCT_W'($urandom_range(127));
                end
                else
                begin
                    hue   = HUE_W'($urandom_range(DEG_TURN));
                    sat   = PCT_W'($urandom_range(PCT_TOP));
                    light = PCT_W'($urandom_range(PCT_TOP));
                end
                send_pixel(hue, sat, light, hsl_convert(hue, sat, light));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_rgb.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: output transfer expected none, actual %h", $time,
                         m_axis_tdata);
            end
            else
            begin
                rgb_t want;
                rgb_t got;
                want = pending_rgb.pop_front();
                got  = m_axis_tdata;
                pixels_checked++;
                if (got.red !== want.red)
                begin
                    mismatch_count++;
                    $display("%0t: red expected %0d, actual %0d", $time, want.red, got.red);
                end
                if (got.green !== want.green)
                begin
                    mismatch_count++;
                    $display("%0t: green expected %0d, actual %0d", $time,
                             want.green, got.green);
                end
                if (got.blue !== want.blue)
                begin
                    mismatch_count++;
                    $display("%0t: blue expected %0d, actual %0d", $time, want.blue, got.blue);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_pixel(PIXEL_TABLE[i].hue, PIXEL_TABLE[i].sat, PIXEL_TABLE[i].light,
                       PIXEL_TABLE[i].known ? PIXEL_TABLE[i].want
                           : hsl_convert(PIXEL_TABLE[i].hue, PIXEL_TABLE[i].sat,
                                         PIXEL_TABLE[i].light));
        end

        run_random_phase(18, 47);
        run_random_phase(47, 18);
        run_random_phase(0, 0);
        s_axis_tvalid <= 1'b0;

        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d pixels (%0d directed, %0d with clamped or wrapped fields).",
                 pixels_sent, DIRECTED_ROWS, clamped_sent);
        $display("Checked %0d output transfers under three idle patterns, %0d mismatches.",
                 pixels_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
